// ===== rtl/dgm_pkg.sv =====
// Shared types, constants and helpers for the design greyness measure block.
// No dependencies; dgm_muldiv, dgm_seq and the core import this package.
package dgm_pkg;

	localparam int DGM_COUNT_BITS  = 17;
	localparam int VALUE_FRAC_BITS = 29;

	localparam logic [63:0] ONE_Q30  = 64'h0000_0000_4000_0000;
	localparam logic [63:0] NORM_MAX = 64'h0000_0100_0000_0000;
	localparam logic [63:0] NORM2_MAX = 64'h0000_0200_0000_0000;
	localparam logic [63:0] T_MAX    = 64'h0000_0010_0000_0000;
	localparam logic [63:0] LN2_Q30  = 64'd744261118;
	localparam logic [63:0] MAX48    = 64'h0000_7FFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		CFG_GAUSS_MODE = 3'd0,
		CFG_DERIV_MODE = 3'd1,
		CFG_SEL_TYPE   = 3'd2,
		CFG_BUMP_WIDTH = 3'd3,
		CFG_GRAD_DIV   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic        gauss_mode;
		logic        derivative_mode;
		logic [2:0]  selected_type;
		logic [31:0] bump_width;
		logic [16:0] gradient_divisor;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] design_value;
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
		logic [2:0]         element_type;
		logic               last_element;
	} elem_t;

	typedef struct packed {
		logic signed [47:0] result_value;
		logic               is_final;
		logic               error_flag;
	} res_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
		logic [63:0] rem;
	} md_rsp_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_CHK,
		MD_DIV
	} md_state_t;

	typedef enum logic [4:0] {
		SQ_IDLE,
		SQ_S_NORM,
		SQ_S_GREY,
		SQ_SD,
		SQ_GRAD,
		SQ_G_NORM,
		SQ_G_T,
		SQ_X_K,
		SQ_X_TERM,
		SQ_X_SHIFT,
		SQ_G_T0,
		SQ_G_GREY,
		SQ_G_G1,
		SQ_G_G2,
		SQ_FIN,
		SQ_LAST,
		SQ_MEAN,
		SQ_EMIT
	} seq_state_t;

	// sign-magnitude to saturated 48-bit two's complement
	function automatic logic signed [47:0] sat48(input logic neg, input logic [63:0] mag);
		logic signed [47:0] r;
		if (neg)
			r = (mag > MAX48) ? 48'sh8000_0000_0000 : -$signed(mag[47:0]);
		else
			r = (mag > MAX48) ? 48'sh7FFF_FFFF_FFFF : $signed(mag[47:0]);
		return r;
	endfunction

endpackage

// ===== rtl/dgm_chan_if.sv =====
// Valid/ready channel interface, payload type set per instance.
// Used with dgm_pkg::elem_t and dgm_pkg::res_t.
interface dgm_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/dgm_muldiv.sv =====
// Bit-serial a*b/c unit: 64 shift-add steps, then 64 restoring divide steps.
// Quotient saturates to all ones (divide steps skipped) when c is zero or it does not fit 64 bits. Uses dgm_pkg.
module dgm_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  dgm_pkg::md_req_t req,
	output dgm_pkg::md_rsp_t rsp
);
	import dgm_pkg::*;

	md_state_t   st_q, st_d;
	logic [63:0] a_q, c_q, hi_q, lo_q;
	logic [5:0]  cnt_q;
	logic        sat_q, done_q;
	logic [64:0] acc, rem2, sub;
	logic        ge, sat_now;

	always_comb begin
		acc     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 65'd0);
		rem2    = {hi_q, lo_q[63]};
		sub     = rem2 - {1'b0, c_q};
		ge      = rem2 >= {1'b0, c_q};
		sat_now = (c_q == 64'd0) || (hi_q >= c_q);
		st_d    = st_q;
		unique case (st_q)
			MD_IDLE: if (req.start) st_d = MD_MUL;
			MD_MUL:  if (cnt_q == 6'd63) st_d = MD_CHK;
			MD_CHK:  st_d = sat_now ? MD_IDLE : MD_DIV;
			MD_DIV:  if (cnt_q == 6'd63) st_d = MD_IDLE;
			default: st_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MD_IDLE;
			cnt_q  <= 6'd0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == MD_CHK && sat_now) || (st_q == MD_DIV && cnt_q == 6'd63);
			if (st_q == MD_MUL || st_q == MD_DIV)
				cnt_q <= cnt_q + 6'd1;
			else
				cnt_q <= 6'd0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			MD_IDLE: if (req.start) begin
				a_q  <= req.a;
				c_q  <= req.c;
				hi_q <= 64'd0;
				lo_q <= req.b;
			end
			MD_MUL: begin
				hi_q <= acc[64:1];
				lo_q <= {acc[0], lo_q[63:1]};
			end
			MD_CHK: sat_q <= sat_now;
			MD_DIV: begin
				hi_q <= ge ? sub[63:0] : rem2[63:0];
				lo_q <= {lo_q[62:0], ge};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sat_q ? {64{1'b1}} : lo_q;
	assign rsp.rem  = hi_q;
endmodule

// ===== rtl/dgm_seq.sv =====
// Per-item sequencer: normalization, greyness, gradient, exp series and run totals,
// each product/quotient issued to dgm_muldiv. Uses dgm_pkg.
module dgm_seq #(
	parameter int COUNT_BITS = dgm_pkg::DGM_COUNT_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dgm_pkg::cfg_t    cfg,
	input  logic             item_valid,
	output logic             item_ready,
	input  dgm_pkg::elem_t   item,
	output logic             res_valid,
	input  logic             res_ready,
	output dgm_pkg::res_t    res,
	output dgm_pkg::md_req_t md_req,
	input  dgm_pkg::md_rsp_t md_rsp
);
	import dgm_pkg::*;

	localparam int F = VALUE_FRAC_BITS;
	localparam logic [63:0] K_Q24    = 64'd1 << 24;
	localparam logic [63:0] K_Q31    = 64'd1 << 31;
	localparam logic [63:0] K_GREY_S = 64'd1 << (58 - F);
	localparam logic [63:0] K_GRAD_S = 64'd1 << (2 * F - 30);
	localparam logic [63:0] K_GRAD_G = 64'd1 << (2 * F - 28);
	localparam logic [63:0] K_FRAC   = 64'd1 << F;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

	seq_state_t st_q, st_d;
	logic       issued_q, last_q, rel_q, bad_q, neg_q, exp_sel_q, sticky_q;
	logic [31:0] s_q, dm_q, e1_q, e0_q;
	logic signed [42:0] nv_q;
	logic [63:0] t_q, sd_q, g_q;
	logic [4:0]  k_q;
	logic [29:0] r_q;
	logic [30:0] term_q;
	logic signed [33:0] esum_q;
	logic [3:0]  idx_q;
	logic signed [47:0] grey_q, grad_q, sum_q;
	logic [COUNT_BITS-1:0] cnt_q;
	res_t        res_q;

	// input-side decode
	logic signed [32:0] span, diff;
	logic        rel_in, bad_in, accept;
	// datapath terms
	logic [31:0] h, d, ed_abs;
	logic [16:0] dv;
	logic [42:0] nv_abs, omx_abs;
	logic signed [42:0] omx;
	logic signed [45:0] cv;
	logic [45:0] cv_abs;
	logic signed [32:0] ed;
	logic [47:0] sum_abs;
	logic [63:0] t_cl, q;
	logic [40:0] qn;
	logic [41:0] qg;
	logic signed [43:0] yv;
	logic signed [48:0] s2;
	logic [32:0] e_pos, e_sh;
	logic        done;

	always_comb begin
		span   = 33'(item.upper_bound) - 33'(item.lower_bound);
		diff   = 33'(item.design_value) - 33'(item.lower_bound);
		rel_in = (cfg.selected_type == 3'd0) || (cfg.selected_type == item.element_type);
		bad_in = rel_in && (span <= 33'sd0);
		accept = item_valid && item_ready;

		h       = (cfg.bump_width == 32'd0) ? 32'd1 : cfg.bump_width;
		dv      = (cfg.gradient_divisor == 17'd0) ? 17'd1 : cfg.gradient_divisor;
		nv_abs  = nv_q[42] ? 43'(-nv_q) : 43'(nv_q);
		omx     = 43'sh0_4000_0000 - nv_q;
		omx_abs = omx[42] ? 43'(-omx) : 43'(omx);
		cv      = 46'sh1_0000_0000 - $signed({nv_q, 3'b000});
		cv_abs  = cv[45] ? 46'(-cv) : 46'(cv);
		d       = (ONE_Q30[31:0] > e0_q) ? (ONE_Q30[31:0] - e0_q) : 32'd1;
		ed      = $signed({1'b0, e1_q}) - $signed({1'b0, e0_q});
		ed_abs  = ed[32] ? 32'(-ed) : ed[31:0];
		sum_abs = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
		t_cl    = (t_q > T_MAX) ? T_MAX : t_q;
		q       = md_rsp.quo;
		done    = md_rsp.done;
		qn      = (q > NORM_MAX) ? NORM_MAX[40:0] : q[40:0];
		qg      = (q > NORM2_MAX) ? NORM2_MAX[41:0] : q[41:0];
		yv      = (neg_q ? -$signed({2'b00, qg}) : $signed({2'b00, qg})) - 44'sh000_4000_0000;
		s2      = 49'(sum_q) + 49'(grey_q);
		e_pos   = esum_q[33] ? 33'd0 : esum_q[32:0];
		e_sh    = e_pos >> k_q;
	end

	always_comb begin
		st_d         = st_q;
		md_req.start = 1'b0;
		md_req.a     = 64'd0;
		md_req.b     = 64'd0;
		md_req.c     = 64'd1;
		unique case (st_q)
			SQ_IDLE: if (accept) begin
				if (!rel_in || bad_in)
					st_d = SQ_FIN;
				else
					st_d = cfg.gauss_mode ? SQ_G_NORM : SQ_S_NORM;
			end
			SQ_S_NORM: begin
				md_req.start = !issued_q;
				md_req.a = 64'(dm_q); md_req.b = ONE_Q30; md_req.c = 64'(s_q);
				if (done) st_d = cfg.derivative_mode ? SQ_SD : SQ_S_GREY;
			end
			SQ_S_GREY: begin
				md_req.start = !issued_q;
				md_req.a = 64'(omx_abs); md_req.b = 64'(nv_abs); md_req.c = K_GREY_S;
				if (done) st_d = SQ_FIN;
			end
			SQ_SD: begin
				md_req.start = !issued_q;
				md_req.a = 64'(s_q); md_req.b = 64'(dv); md_req.c = 64'd1;
				if (done) st_d = SQ_GRAD;
			end
			SQ_GRAD: begin
				md_req.start = !issued_q;
				md_req.a = cfg.gauss_mode ? g_q : 64'(cv_abs);
				md_req.b = cfg.gauss_mode ? K_GRAD_G : K_GRAD_S;
				md_req.c = sd_q;
				if (done) st_d = SQ_FIN;
			end
			SQ_G_NORM: begin
				md_req.start = !issued_q;
				md_req.a = 64'(dm_q); md_req.b = K_Q31; md_req.c = 64'(s_q);
				if (done) st_d = SQ_G_T;
			end
			SQ_G_T: begin
				md_req.start = !issued_q;
				md_req.a = 64'(nv_abs); md_req.b = 64'(nv_abs); md_req.c = {26'd0, h, 6'd0};
				if (done) st_d = SQ_X_K;
			end
			SQ_X_K: begin
				md_req.start = !issued_q;
				md_req.a = t_cl; md_req.b = 64'd1; md_req.c = LN2_Q30;
				if (done) st_d = (q > 64'd30) ? SQ_X_SHIFT : SQ_X_TERM;
			end
			SQ_X_TERM: begin
				md_req.start = !issued_q;
				md_req.a = 64'(term_q); md_req.b = 64'(r_q); md_req.c = {30'd0, idx_q, 30'd0};
				if (done && idx_q == 4'd12) st_d = SQ_X_SHIFT;
			end
			SQ_X_SHIFT: begin
				if (!exp_sel_q)
					st_d = SQ_G_T0;
				else
					st_d = cfg.derivative_mode ? SQ_G_G1 : SQ_G_GREY;
			end
			SQ_G_T0: begin
				md_req.start = !issued_q;
				md_req.a = ONE_Q30; md_req.b = K_Q24; md_req.c = 64'(h);
				if (done) st_d = SQ_X_K;
			end
			SQ_G_GREY: begin
				md_req.start = !issued_q;
				md_req.a = 64'(ed_abs); md_req.b = K_FRAC; md_req.c = 64'(d);
				if (done) st_d = SQ_FIN;
			end
			SQ_G_G1: begin
				md_req.start = !issued_q;
				md_req.a = 64'(nv_abs); md_req.b = 64'(e1_q); md_req.c = 64'(d);
				if (done) st_d = SQ_G_G2;
			end
			SQ_G_G2: begin
				md_req.start = !issued_q;
				md_req.a = g_q; md_req.b = K_Q24; md_req.c = 64'(h);
				if (done) st_d = SQ_SD;
			end
			SQ_FIN: begin
				if (cfg.derivative_mode)
					st_d = SQ_EMIT;
				else
					st_d = last_q ? SQ_LAST : SQ_IDLE;
			end
			SQ_LAST: st_d = (cnt_q == '0) ? SQ_EMIT : SQ_MEAN;
			SQ_MEAN: begin
				md_req.start = !issued_q;
				md_req.a = 64'(sum_abs); md_req.b = 64'd1; md_req.c = 64'(cnt_q);
				if (done) st_d = SQ_EMIT;
			end
			SQ_EMIT: if (res_ready) st_d = SQ_IDLE;
			default: st_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= SQ_IDLE;
			issued_q <= 1'b0;
			sum_q    <= 48'sd0;
			cnt_q    <= '0;
			sticky_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (md_req.start)
				issued_q <= 1'b1;
			else if (done)
				issued_q <= 1'b0;
			if (st_q == SQ_FIN && !cfg.derivative_mode) begin
				if (bad_q) begin
					sticky_q <= 1'b1;
				end else if (rel_q) begin
					if (s2[48] != s2[47])
						sum_q <= s2[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
					else
						sum_q <= s2[47:0];
					if (cnt_q != CNT_MAX)
						cnt_q <= cnt_q + CNT_ONE;
				end
			end
			if (st_q == SQ_EMIT && res_ready && last_q) begin
				sum_q    <= 48'sd0;
				cnt_q    <= '0;
				sticky_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			SQ_IDLE: if (accept) begin
				last_q <= item.last_element;
				rel_q  <= rel_in;
				bad_q  <= bad_in;
				s_q    <= span[31:0];
				neg_q  <= diff[32];
				dm_q   <= diff[32] ? 32'(-diff) : diff[31:0];
			end
			SQ_S_NORM: if (done) nv_q <= neg_q ? -$signed({2'b00, qn}) : $signed({2'b00, qn});
			SQ_G_NORM: if (done) begin
				if (yv > 44'sh100_0000_0000)
					nv_q <= 43'sh100_0000_0000;
				else if (yv < -44'sh100_0000_0000)
					nv_q <= -43'sh100_0000_0000;
				else
					nv_q <= 43'(yv);
			end
			SQ_S_GREY: if (done) grey_q <= sat48(omx[42] != nv_q[42], q);
			SQ_SD:     if (done) sd_q <= q;
			SQ_GRAD: if (done)
				grad_q <= sat48(cfg.gauss_mode ? (!nv_q[42] && nv_q != 43'sd0) : cv[45], q);
			SQ_G_T: if (done) begin
				t_q       <= q;
				exp_sel_q <= 1'b0;
			end
			SQ_G_T0: if (done) begin
				t_q       <= q;
				exp_sel_q <= 1'b1;
			end
			SQ_X_K: if (done) begin
				if (q > 64'd30) begin
					esum_q <= 34'sd0;
					k_q    <= 5'd0;
				end else begin
					k_q    <= q[4:0];
					r_q    <= md_rsp.rem[29:0];
					term_q <= ONE_Q30[30:0];
					esum_q <= 34'(ONE_Q30);
					idx_q  <= 4'd1;
				end
			end
			SQ_X_TERM: if (done) begin
				term_q <= q[30:0];
				esum_q <= idx_q[0] ? esum_q - $signed({3'b000, q[30:0]})
					: esum_q + $signed({3'b000, q[30:0]});
				idx_q  <= idx_q + 4'd1;
			end
			SQ_X_SHIFT: begin
				if (exp_sel_q)
					e0_q <= e_sh[31:0];
				else
					e1_q <= e_sh[31:0];
			end
			SQ_G_GREY: if (done) grey_q <= sat48(ed[32], q);
			SQ_G_G1, SQ_G_G2: if (done) g_q <= q;
			SQ_FIN: if (cfg.derivative_mode) begin
				res_q.result_value <= (rel_q && !bad_q) ? grad_q : 48'sd0;
				res_q.is_final     <= last_q;
				res_q.error_flag   <= bad_q;
			end
			SQ_LAST: begin
				res_q.result_value <= 48'sd0;
				res_q.is_final     <= 1'b1;
				res_q.error_flag   <= 1'b1;
			end
			SQ_MEAN: if (done) begin
				res_q.result_value <= sat48(sum_q[47], q);
				res_q.is_final     <= 1'b1;
				res_q.error_flag   <= sticky_q;
			end
			default: ;
		endcase
	end

	assign item_ready = (st_q == SQ_IDLE);
	assign res_valid  = (st_q == SQ_EMIT);
	assign res        = res_q;
endmodule

// ===== rtl/design_greyness_measure_core.sv =====
// Top level of the design greyness measure: configuration registers, output register,
// sequencer and shared multiply-divide unit. Uses dgm_pkg, dgm_chan_if, dgm_seq, dgm_muldiv.
//
//   port     dir  payload              notes
//   elem     in   dgm_pkg::elem_t      one design element per item
//   result   out  dgm_pkg::res_t       gradient, or mean on last element
//   cfg_*    in   index 3b, data 32b   write only; user must write only while idle, not enforced
//
// One item at a time. Each product/quotient runs through the bit-serial multiply-divide
// unit as 64 add steps, then 64 subtract steps unless the quotient saturates. Per item:
// standard evaluation 2, standard gradient 3, Gauss evaluation up to 30, Gauss gradient
// up to 33 products/quotients, plus one for the mean on the last element in evaluation
// mode; an irrelevant element or one with a bad span takes none. The output register lets
// the next item start while a result waits. Reset clears control and run totals at once.
module design_greyness_measure_core #(
	parameter int COUNT_BITS = dgm_pkg::DGM_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	dgm_chan_if.sink    elem,
	dgm_chan_if.source  result,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import dgm_pkg::*;

	cfg_t    cfg_q;
	res_t    seq_res, out_q;
	elem_t   item;
	md_req_t md_req;
	md_rsp_t md_rsp;
	logic    seq_res_valid, seq_res_ready, out_valid_q, load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gauss_mode       <= 1'b0;
			cfg_q.derivative_mode  <= 1'b0;
			cfg_q.selected_type    <= 3'd0;
			cfg_q.bump_width       <= 32'h0100_0000;
			cfg_q.gradient_divisor <= 17'd1;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_GAUSS_MODE: cfg_q.gauss_mode       <= cfg_wdata[0];
				CFG_DERIV_MODE: cfg_q.derivative_mode  <= cfg_wdata[0];
				CFG_SEL_TYPE:   cfg_q.selected_type    <= cfg_wdata[2:0];
				CFG_BUMP_WIDTH: cfg_q.bump_width       <= cfg_wdata;
				CFG_GRAD_DIV:   cfg_q.gradient_divisor <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	assign item = elem.data;

	dgm_seq #(.COUNT_BITS(COUNT_BITS)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (elem.valid),
		.item_ready (elem.ready),
		.item       (item),
		.res_valid  (seq_res_valid),
		.res_ready  (seq_res_ready),
		.res        (seq_res),
		.md_req     (md_req),
		.md_rsp     (md_rsp)
	);

	dgm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign seq_res_ready = !out_valid_q || result.ready;
	assign load          = seq_res_valid && seq_res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= seq_res;
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;
endmodule
